// ----- hw/rtl/efla_pkg.sv -----
`default_nettype none
package efla_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		REQ_MALLOC = 2'd0,
		REQ_FREE   = 2'd1,
		REQ_INIT   = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_IGNORED = 2'd2,
		ST_NOINIT  = 2'd3
	} status_t;

	localparam word_t       SIZE_MASK    = 32'hFFFF_FFF8;
	localparam word_t       PROLOGUE_TAG = 32'd9;
	localparam word_t       EPILOGUE_TAG = 32'd1;
	localparam word_t       MIN_BLOCK    = 32'd16;
	localparam logic [16:0] START_BYTES  = 17'd16;
	localparam logic [16:0] CHUNK_MIN    = 17'd8;
	localparam logic [16:0] CHUNK_RESET  = 17'd4096;

	// one heap access per cycle: a read, a write or nothing
	typedef struct packed {
		logic  re;
		logic  we;
		word_t addr;
		word_t wdata;
	} efla_mem_req_t;

	typedef enum logic [6:0] {
		S_IDLE, S_FIN,
		S_I0, S_I1, S_I2, S_I3, S_IRET,
		S_G0, S_G1, S_G2, S_G3, S_G4,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_MEND,
		S_MA0, S_MA1, S_MA2, S_MA3, S_MA4,
		S_MB0, S_MB1, S_MB2, S_MB3, S_MB4, S_MB5, S_MB6, S_MB7,
		S_MC0, S_MC1, S_MC2, S_MC3, S_MC4, S_MC5, S_MC6, S_MC7,
		S_MC8, S_MC9, S_MC10, S_MC11, S_MC12, S_MC13,
		S_U0, S_U1, S_U2, S_U3,
		S_P0, S_P1, S_P2, S_P3,
		S_FF0, S_FF1, S_FF2, S_MG0, S_MG1,
		S_CV0, S_CV1, S_CS0, S_CS1, S_CS2, S_CS3, S_CN0, S_CVEND,
		S_FR0, S_FR1, S_FR2, S_FR3
	} state_t;

	function automatic word_t size_of(input word_t w);
		return w & SIZE_MASK;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/efla_heap_ram.sv -----
`default_nettype none
module efla_heap_ram import efla_pkg::*; #(
	parameter int unsigned HEAP_WORDS = 16384
) (
	input  logic          clk,
	input  efla_mem_req_t req,
	output word_t         rdata
);

	localparam int unsigned AW = $clog2(HEAP_WORDS);

	word_t          mem [HEAP_WORDS];
	word_t          rdata_q;
	logic           hit_q;
	logic           hit;
	logic [AW-1:0]  idx;

	// bytes beyond the array read as zero and drop writes
	assign hit   = req.addr[31:2] < 30'(HEAP_WORDS);
	assign idx   = req.addr[AW+1:2];
	assign rdata = hit_q ? rdata_q : '0;

	always_ff @(posedge clk) begin
		if (req.we && hit) begin
			mem[idx] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[idx];
			hit_q   <= hit;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/explicit_free_list_allocator_unit.sv -----
`default_nettype none
// Malloc examines free blocks on the list first fit, then splits, grows and coalesces as needed.
// Throughput: one request at a time; each step makes at most one access to the single-port heap RAM.
// A new request is taken while the previous result still waits on the output register.
// Reset (arst_n low) clears control state; heap RAM is not cleared, the heap counts as
//   uninitialized until an init request.
module explicit_free_list_allocator_unit import efla_pkg::*; #(
	parameter int unsigned HEAP_WORDS = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [16:0] request_size, [32:17] block_address, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] result_address, [17:16] status, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data   // chunk_size
);

	// usable bytes, capped at the 16-bit offset range
	localparam longint unsigned CAP_L = (longint'(HEAP_WORDS) * 4 > 65536) ?
		65536 : longint'(HEAP_WORDS) * 4;
	localparam word_t CAP = 32'(CAP_L);

	// control state
	state_t      st_q, st_d;
	state_t      ret_u_q, ret_u_d;   // return from unlink
	state_t      ret_p_q, ret_p_d;   // return from push
	state_t      ret_m_q, ret_m_d;   // return from merge
	state_t      ret_g_q, ret_g_d;   // return from grow
	logic [15:0] head_q, head_d;
	logic [12:0] count_q, count_d;
	logic [16:0] hend_q, hend_d;
	logic        ready_q, ready_d;
	logic [16:0] chunk_q;
	logic        m_valid_q, m_valid_d;

	// working registers
	word_t       asz_q, asz_d;
	word_t       gsz_q, gsz_d;
	word_t       mbp_q, mbp_d;
	word_t       msz_q, msz_d;
	word_t       mprev_q, mprev_d;
	word_t       tmp_q, tmp_d;
	word_t       ubp_q, ubp_d;
	word_t       up_q, up_d;
	word_t       un_q, un_d;
	logic        mpa_q, mpa_d;
	logic [15:0] bp_q, bp_d;
	logic [15:0] pbp_q, pbp_d;
	logic [15:0] gres_q, gres_d;
	logic [15:0] res_q, res_d;
	status_t     stat_q, stat_d;
	logic [12:0] fcnt_q, fcnt_d;
	logic [15:0] out_res_q, out_res_d;
	status_t     out_stat_q, out_stat_d;

	efla_mem_req_t mreq;
	word_t         rd;
	word_t         rsz;
	word_t         ga;
	req_kind_t     in_kind;
	logic [16:0]   in_req;
	logic [15:0]   in_addr;
	logic [16:0]   chunk_eff;

	efla_heap_ram #(
		.HEAP_WORDS(HEAP_WORDS)
	) u_ram (
		.clk  (clk),
		.req  (mreq),
		.rdata(rd)
	);

	assign in_kind   = req_kind_t'(s_tuser);
	assign in_req    = s_tdata[16:0];
	assign in_addr   = s_tdata[32:17];
	assign rsz       = size_of(rd);
	assign ga        = (gsz_q + 32'd15) & SIZE_MASK;
	// chunk sizes below one double word act as one double word
	assign chunk_eff = (chunk_q < CHUNK_MIN) ? CHUNK_MIN : chunk_q;

	assign s_tready  = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {6'd0, out_stat_q, out_res_q};

	always_comb begin
		st_d       = st_q;
		ret_u_d    = ret_u_q;
		ret_p_d    = ret_p_q;
		ret_m_d    = ret_m_q;
		ret_g_d    = ret_g_q;
		head_d     = head_q;
		count_d    = count_q;
		hend_d     = hend_q;
		ready_d    = ready_q;
		m_valid_d  = m_valid_q && !m_tready;
		asz_d      = asz_q;
		gsz_d      = gsz_q;
		mbp_d      = mbp_q;
		msz_d      = msz_q;
		mprev_d    = mprev_q;
		tmp_d      = tmp_q;
		ubp_d      = ubp_q;
		up_d       = up_q;
		un_d       = un_q;
		mpa_d      = mpa_q;
		bp_d       = bp_q;
		pbp_d      = pbp_q;
		gres_d     = gres_q;
		res_d      = res_q;
		stat_d     = stat_q;
		fcnt_d     = fcnt_q;
		out_res_d  = out_res_q;
		out_stat_d = out_stat_q;
		mreq       = '0;

		case (st_q)
			// take a request and sort out the trivial answers at once
			S_IDLE: begin
				if (s_tvalid) begin
					res_d  = '0;
					stat_d = ST_OK;
					case (in_kind)
						REQ_INIT: begin
							st_d = S_I0;
						end
						REQ_MALLOC: begin
							if (!ready_q) begin
								stat_d = ST_NOINIT;
								st_d   = S_FIN;
							end else if (in_req == '0) begin
								stat_d = ST_IGNORED;
								st_d   = S_FIN;
							end else begin
								asz_d = (in_req <= 17'd8) ? MIN_BLOCK :
									((32'(in_req) + 32'd15) & SIZE_MASK);
								st_d  = S_FF0;
							end
						end
						REQ_FREE: begin
							if (in_addr == '0 || in_addr[2:0] != 3'd0) begin
								stat_d = ST_IGNORED;
								st_d   = S_FIN;
							end else if (!ready_q) begin
								stat_d = ST_NOINIT;
								st_d   = S_FIN;
							end else begin
								bp_d = in_addr;
								st_d = S_FR0;
							end
						end
						default: begin
							stat_d = ST_IGNORED;
							st_d   = S_FIN;
						end
					endcase
				end
			end
			// hand the word to the output register once it is free
			S_FIN: begin
				if (!m_valid_q || m_tready) begin
					m_valid_d  = 1'b1;
					out_res_d  = res_q;
					out_stat_d = stat_q;
					st_d       = S_IDLE;
				end
			end

			// init: padding, prologue, epilogue, then grow by one chunk
			S_I0: begin
				mreq.we = 1'b1; mreq.addr = 32'd0; mreq.wdata = '0;
				st_d = S_I1;
			end
			S_I1: begin
				mreq.we = 1'b1; mreq.addr = 32'd4; mreq.wdata = PROLOGUE_TAG;
				st_d = S_I2;
			end
			S_I2: begin
				mreq.we = 1'b1; mreq.addr = 32'd8; mreq.wdata = PROLOGUE_TAG;
				st_d = S_I3;
			end
			S_I3: begin
				mreq.we = 1'b1; mreq.addr = 32'd12; mreq.wdata = EPILOGUE_TAG;
				hend_d  = START_BYTES;
				head_d  = '0;
				count_d = '0;
				ready_d = 1'b1;
				gsz_d   = 32'(chunk_eff);
				ret_g_d = S_IRET;
				st_d    = S_G0;
			end
			S_IRET: begin
				if (gres_q == '0) begin
					stat_d = ST_OOM;
				end
				st_d = S_FIN;
			end

			// grow: new free block at the old end, fresh epilogue, then coalesce
			S_G0: begin
				if (ga > CAP || 32'(hend_q) > CAP - ga) begin
					gres_d = '0;
					st_d   = ret_g_q;
				end else begin
					gsz_d = ga;
					mbp_d = 32'(hend_q);
					st_d  = S_G1;
				end
			end
			S_G1: begin
				mreq.we = 1'b1; mreq.addr = mbp_q - 32'd4; mreq.wdata = gsz_q;
				st_d = S_G2;
			end
			S_G2: begin
				mreq.we = 1'b1; mreq.addr = mbp_q + gsz_q - 32'd8; mreq.wdata = gsz_q;
				st_d = S_G3;
			end
			S_G3: begin
				mreq.we = 1'b1; mreq.addr = mbp_q + gsz_q - 32'd4; mreq.wdata = EPILOGUE_TAG;
				hend_d  = 17'(mbp_q + gsz_q);
				ret_m_d = S_G4;
				st_d    = S_M0;
			end
			S_G4: begin
				gres_d = mbp_q[15:0];
				st_d   = ret_g_q;
			end

			// merge: look at both neighbors, then one of four cases
			S_M0: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd8;
				st_d = S_M1;
			end
			S_M1: begin
				mprev_d = mbp_q - rsz;
				mreq.re = 1'b1; mreq.addr = mbp_q - rsz - 32'd4;
				st_d = S_M2;
			end
			S_M2: begin
				mpa_d   = rd[0];
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd4;
				st_d = S_M3;
			end
			S_M3: begin
				msz_d   = rsz;
				mreq.re = 1'b1; mreq.addr = mbp_q + rsz - 32'd4;
				st_d = S_M4;
			end
			S_M4: begin
				if (mpa_q && rd[0]) begin
					pbp_d   = mbp_q[15:0];
					ret_p_d = S_MEND;
					st_d    = S_P0;
				end else if (mpa_q) begin
					ubp_d   = mbp_q + msz_q;
					ret_u_d = S_MA0;
					st_d    = S_U0;
				end else if (rd[0]) begin
					ubp_d   = mprev_q;
					ret_u_d = S_MB0;
					st_d    = S_U0;
				end else begin
					ubp_d   = mprev_q;
					ret_u_d = S_MC0;
					st_d    = S_U0;
				end
			end
			S_MEND: begin
				st_d = ret_m_q;
			end

			// next neighbor free: absorb it
			S_MA0: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd4;
				st_d = S_MA1;
			end
			S_MA1: begin
				mreq.re = 1'b1; mreq.addr = mbp_q + rsz - 32'd4;
				st_d = S_MA2;
			end
			S_MA2: begin
				msz_d   = msz_q + rsz;
				mreq.we = 1'b1; mreq.addr = mbp_q - 32'd4; mreq.wdata = msz_q + rsz;
				st_d = S_MA3;
			end
			S_MA3: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd4;
				st_d = S_MA4;
			end
			S_MA4: begin
				mreq.we = 1'b1; mreq.addr = mbp_q + rsz - 32'd8; mreq.wdata = msz_q;
				pbp_d   = mbp_q[15:0];
				ret_p_d = S_MEND;
				st_d    = S_P0;
			end

			// previous neighbor free: fold into it
			S_MB0: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd8;
				st_d = S_MB1;
			end
			S_MB1: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - rsz - 32'd4;
				st_d = S_MB2;
			end
			S_MB2: begin
				msz_d   = msz_q + rsz;
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd8;
				st_d = S_MB3;
			end
			S_MB3: begin
				mreq.we = 1'b1; mreq.addr = mbp_q - rsz - 32'd4; mreq.wdata = msz_q;
				st_d = S_MB4;
			end
			S_MB4: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd4;
				st_d = S_MB5;
			end
			S_MB5: begin
				mreq.we = 1'b1; mreq.addr = mbp_q + rsz - 32'd8; mreq.wdata = msz_q;
				st_d = S_MB6;
			end
			S_MB6: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd8;
				st_d = S_MB7;
			end
			S_MB7: begin
				mbp_d   = mbp_q - rsz;
				pbp_d   = 16'(mbp_q - rsz);
				ret_p_d = S_MEND;
				st_d    = S_P0;
			end

			// both neighbors free: unlink the next one too, then span all three
			S_MC0: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd4;
				st_d = S_MC1;
			end
			S_MC1: begin
				ubp_d   = mbp_q + rsz;
				ret_u_d = S_MC2;
				st_d    = S_U0;
			end
			S_MC2: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd8;
				st_d = S_MC3;
			end
			S_MC3: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - rsz - 32'd4;
				st_d = S_MC4;
			end
			S_MC4: begin
				msz_d   = msz_q + rsz;
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd4;
				st_d = S_MC5;
			end
			S_MC5: begin
				tmp_d   = mbp_q + rsz;
				mreq.re = 1'b1; mreq.addr = mbp_q + rsz - 32'd4;
				st_d = S_MC6;
			end
			S_MC6: begin
				mreq.re = 1'b1; mreq.addr = tmp_q + rsz - 32'd8;
				st_d = S_MC7;
			end
			S_MC7: begin
				msz_d   = msz_q + rsz;
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd8;
				st_d = S_MC8;
			end
			S_MC8: begin
				mreq.we = 1'b1; mreq.addr = mbp_q - rsz - 32'd4; mreq.wdata = msz_q;
				st_d = S_MC9;
			end
			S_MC9: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd4;
				st_d = S_MC10;
			end
			S_MC10: begin
				tmp_d   = mbp_q + rsz;
				mreq.re = 1'b1; mreq.addr = mbp_q + rsz - 32'd4;
				st_d = S_MC11;
			end
			S_MC11: begin
				mreq.we = 1'b1; mreq.addr = tmp_q + rsz - 32'd8; mreq.wdata = msz_q;
				st_d = S_MC12;
			end
			S_MC12: begin
				mreq.re = 1'b1; mreq.addr = mbp_q - 32'd8;
				st_d = S_MC13;
			end
			S_MC13: begin
				mbp_d   = mbp_q - rsz;
				pbp_d   = 16'(mbp_q - rsz);
				ret_p_d = S_MEND;
				st_d    = S_P0;
			end

			// unlink: read both links, patch the neighbors
			S_U0: begin
				mreq.re = 1'b1; mreq.addr = ubp_q;
				st_d = S_U1;
			end
			S_U1: begin
				up_d    = rd;
				mreq.re = 1'b1; mreq.addr = ubp_q + 32'd4;
				st_d = S_U2;
			end
			S_U2: begin
				un_d    = rd;
				count_d = count_q - 13'd1;
				st_d    = ret_u_q;
				if (up_q == '0 && rd == '0) begin
					head_d = '0;
				end else if (up_q == '0) begin
					head_d  = rd[15:0];
					mreq.we = 1'b1; mreq.addr = 32'(rd[15:0]); mreq.wdata = '0;
				end else if (rd == '0) begin
					mreq.we = 1'b1; mreq.addr = up_q + 32'd4; mreq.wdata = '0;
				end else begin
					mreq.we = 1'b1; mreq.addr = up_q + 32'd4; mreq.wdata = rd;
					st_d = S_U3;
				end
			end
			S_U3: begin
				mreq.we = 1'b1; mreq.addr = un_q; mreq.wdata = up_q;
				st_d = ret_u_q;
			end

			// push at the head of the list
			S_P0: begin
				mreq.we = 1'b1;
				if (count_q == '0) begin
					mreq.addr = 32'(pbp_q); mreq.wdata = '0;
					st_d = S_P1;
				end else begin
					mreq.addr = 32'(head_q); mreq.wdata = 32'(pbp_q);
					st_d = S_P2;
				end
			end
			S_P1: begin
				mreq.we = 1'b1; mreq.addr = 32'(pbp_q) + 32'd4; mreq.wdata = '0;
				head_d  = pbp_q;
				count_d = count_q + 13'd1;
				st_d    = ret_p_q;
			end
			S_P2: begin
				mreq.we = 1'b1; mreq.addr = 32'(pbp_q); mreq.wdata = '0;
				st_d = S_P3;
			end
			S_P3: begin
				mreq.we = 1'b1; mreq.addr = 32'(pbp_q) + 32'd4; mreq.wdata = 32'(head_q);
				head_d  = pbp_q;
				count_d = count_q + 13'd1;
				st_d    = ret_p_q;
			end

			// first fit: size word, then next link, one read per cycle
			S_FF0: begin
				if (count_q == '0) begin
					st_d = S_MG0;
				end else begin
					bp_d    = head_q;
					fcnt_d  = '0;
					mreq.re = 1'b1; mreq.addr = 32'(head_q) - 32'd4;
					st_d = S_FF1;
				end
			end
			S_FF1: begin
				if (asz_q <= rsz) begin
					st_d = S_CV0;
				end else begin
					mreq.re = 1'b1; mreq.addr = 32'(bp_q) + 32'd4;
					st_d = S_FF2;
				end
			end
			S_FF2: begin
				bp_d   = rd[15:0];
				fcnt_d = fcnt_q + 13'd1;
				if (({1'b0, fcnt_q} + 14'd1) < {1'b0, count_q}) begin
					mreq.re = 1'b1; mreq.addr = 32'(rd[15:0]) - 32'd4;
					st_d = S_FF1;
				end else begin
					st_d = S_MG0;
				end
			end
			S_MG0: begin
				gsz_d   = (asz_q > 32'(chunk_eff)) ? asz_q : 32'(chunk_eff);
				ret_g_d = S_MG1;
				st_d    = S_G0;
			end
			S_MG1: begin
				if (gres_q == '0) begin
					stat_d = ST_OOM;
					st_d   = S_FIN;
				end else begin
					bp_d = gres_q;
					st_d = S_CV0;
				end
			end

			// carve: split off a remainder of a minimum block or more, else hand out the whole block
			S_CV0: begin
				mreq.re = 1'b1; mreq.addr = 32'(bp_q) - 32'd4;
				st_d = S_CV1;
			end
			S_CV1: begin
				if (rsz - asz_q >= MIN_BLOCK) begin
					tmp_d   = rsz - asz_q;
					ubp_d   = 32'(bp_q);
					ret_u_d = S_CS0;
					st_d    = S_U0;
				end else begin
					tmp_d   = rsz;
					mreq.we = 1'b1; mreq.addr = 32'(bp_q) - 32'd4; mreq.wdata = rsz | 32'd1;
					st_d = S_CN0;
				end
			end
			S_CS0: begin
				mreq.we = 1'b1; mreq.addr = 32'(bp_q) - 32'd4; mreq.wdata = asz_q | 32'd1;
				st_d = S_CS1;
			end
			S_CS1: begin
				mreq.we = 1'b1; mreq.addr = 32'(bp_q) + asz_q - 32'd8;
				mreq.wdata = asz_q | 32'd1;
				st_d = S_CS2;
			end
			S_CS2: begin
				mreq.we = 1'b1; mreq.addr = 32'(bp_q) + asz_q - 32'd4; mreq.wdata = tmp_q;
				st_d = S_CS3;
			end
			S_CS3: begin
				mreq.we = 1'b1; mreq.addr = 32'(bp_q) + asz_q + tmp_q - 32'd8;
				mreq.wdata = tmp_q;
				pbp_d   = 16'(32'(bp_q) + asz_q);
				ret_p_d = S_CVEND;
				st_d    = S_P0;
			end
			S_CN0: begin
				mreq.we = 1'b1; mreq.addr = 32'(bp_q) + tmp_q - 32'd8;
				mreq.wdata = tmp_q | 32'd1;
				ubp_d   = 32'(bp_q);
				ret_u_d = S_CVEND;
				st_d    = S_U0;
			end
			S_CVEND: begin
				res_d = bp_q;
				st_d  = S_FIN;
			end

			// free: clear the allocated flag in header and footer, then merge
			S_FR0: begin
				mreq.re = 1'b1; mreq.addr = 32'(bp_q) - 32'd4;
				st_d = S_FR1;
			end
			S_FR1: begin
				msz_d   = rsz;
				mreq.we = 1'b1; mreq.addr = 32'(bp_q) - 32'd4; mreq.wdata = rsz;
				st_d = S_FR2;
			end
			S_FR2: begin
				mreq.re = 1'b1; mreq.addr = 32'(bp_q) - 32'd4;
				st_d = S_FR3;
			end
			S_FR3: begin
				mreq.we = 1'b1; mreq.addr = 32'(bp_q) + rsz - 32'd8; mreq.wdata = msz_q;
				mbp_d   = 32'(bp_q);
				ret_m_d = S_FIN;
				st_d    = S_M0;
			end

			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	// control state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			ret_u_q   <= S_IDLE;
			ret_p_q   <= S_IDLE;
			ret_m_q   <= S_IDLE;
			ret_g_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			hend_q    <= '0;
			ready_q   <= 1'b0;
			chunk_q   <= CHUNK_RESET;
			m_valid_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			ret_u_q   <= ret_u_d;
			ret_p_q   <= ret_p_d;
			ret_m_q   <= ret_m_d;
			ret_g_q   <= ret_g_d;
			head_q    <= head_d;
			count_q   <= count_d;
			hend_q    <= hend_d;
			ready_q   <= ready_d;
			m_valid_q <= m_valid_d;
			if (cfg_valid) begin
				chunk_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		asz_q      <= asz_d;
		gsz_q      <= gsz_d;
		mbp_q      <= mbp_d;
		msz_q      <= msz_d;
		mprev_q    <= mprev_d;
		tmp_q      <= tmp_d;
		ubp_q      <= ubp_d;
		up_q       <= up_d;
		un_q       <= un_d;
		mpa_q      <= mpa_d;
		bp_q       <= bp_d;
		pbp_q      <= pbp_d;
		gres_q     <= gres_d;
		res_q      <= res_d;
		stat_q     <= stat_d;
		fcnt_q     <= fcnt_d;
		out_res_q  <= out_res_d;
		out_stat_q <= out_stat_d;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/efla_checker.sv -----
`default_nettype none
module efla_checker import efla_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// any failure status carries a zero address
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[17:16] != ST_OK) |-> (m_tdata[15:0] == 16'd0))
		else $error("failed request returned an address");

	// one request in flight: ready drops after a word is taken
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

endmodule

bind explicit_free_list_allocator_unit efla_checker u_efla_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
